>>> rtl/core/pmpr_pkg.sv
package pmpr_pkg;

   localparam int unsigned MAX_WIDTH  = 4096;
   localparam int unsigned COL_W      = $clog2(MAX_WIDTH);
   localparam int unsigned PIX_W      = 8;
   localparam int unsigned WIDTH_W    = 13;
   localparam int unsigned HEIGHT_W   = 16;
   localparam int unsigned CSR_DATA_W = 16;
   localparam int unsigned CSR_IDX_W  = 1;

   localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(256);
   localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(256);
   localparam logic [WIDTH_W-1:0]  WIDTH_LIMIT  = WIDTH_W'(MAX_WIDTH);

   typedef logic [PIX_W-1:0] pixel_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   // neighborhood of the current pixel, handed to the predictor
   typedef struct packed {
      logic      first_row;
      logic      first_col;
      pixel_type left;
      pixel_type top;
      pixel_type top_left;
   } nbr_type;

endpackage

>>> rtl/core/pmpr_if.sv
interface pmpr_req_if;
   logic                valid;
   logic                ready;
   pmpr_pkg::pixel_type pixel;

   modport source (output valid, output pixel, input ready);
   modport sink   (input valid, input pixel, output ready);
endinterface

interface pmpr_rsp_if;
   logic                valid;
   logic                ready;
   pmpr_pkg::pixel_type residual;
   logic                frame_end;

   modport source (output valid, output residual, output frame_end, input ready);
   modport sink   (input valid, input residual, input frame_end, output ready);
endinterface

>>> rtl/core/pmpr_ram.sv
module pmpr_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/pmpr_predict.sv
module pmpr_predict (
   input  pmpr_pkg::nbr_type   nbr,
   input  pmpr_pkg::pixel_type pixel,
   output pmpr_pkg::pixel_type residual
);

   pmpr_pkg::pixel_type lo;
   pmpr_pkg::pixel_type hi;
   pmpr_pkg::pixel_type grad;
   pmpr_pkg::pixel_type med;
   pmpr_pkg::pixel_type pred;

   always_comb begin
      // gradient wraps to 8 bits
      grad = nbr.left + nbr.top - nbr.top_left;
      lo   = (nbr.left < nbr.top) ? nbr.left : nbr.top;
      hi   = (nbr.left < nbr.top) ? nbr.top  : nbr.left;
      priority if (grad <= lo) begin
         med = lo;
      end else if (grad >= hi) begin
         med = hi;
      end else begin
         med = grad;
      end

      priority if (nbr.first_row && nbr.first_col) begin
         pred = '0;
      end else if (nbr.first_row) begin
         pred = nbr.left;
      end else if (nbr.first_col) begin
         pred = nbr.top;
      end else begin
         pred = med;
      end
   end

   assign residual = pixel - pred;

endmodule

>>> rtl/core/pixel_median_predictor_residual.sv
// channel | dir | payload                      | transfer when
// --------+-----+------------------------------+-----------------------------------
// req     | in  | pixel[7:0]                   | req_chan.valid & req_chan.ready
// rsp     | out | residual[7:0], frame_end     | rsp_chan.valid & rsp_chan.ready
// csr     | in  | csr_index, csr_wdata[15:0]   | csr_we
//
// One pixel per cycle; the residual is loaded into the result register in the cycle after
// the pixel transfers. The row store read for the next column is issued in the
// transfer cycle so the above pixel is ready at the next one; a same-column rewrite
// is forwarded. Reset clears counters, neighbors and the result valid; width and
// height return to 256. The result register stalls the input only while it holds
// an untaken residual and rsp is not ready.
module pixel_median_predictor_residual (
   input  logic                                  clock,
   input  logic                                  reset,
   pmpr_req_if.sink                              req_chan,
   pmpr_rsp_if.source                            rsp_chan,
   input  logic                                  csr_we,
   input  logic [pmpr_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [pmpr_pkg::CSR_DATA_W-1:0]       csr_wdata
);

   logic [pmpr_pkg::WIDTH_W-1:0]  width_ff;
   logic [pmpr_pkg::HEIGHT_W-1:0] height_ff;
   logic [pmpr_pkg::WIDTH_W-1:0]  width_eff;
   logic [pmpr_pkg::HEIGHT_W-1:0] height_eff;

   logic [pmpr_pkg::COL_W-1:0]    col_ff, col_in;
   logic [pmpr_pkg::HEIGHT_W-1:0] row_ff, row_in;
   pmpr_pkg::pixel_type           left_ff, left_in;
   pmpr_pkg::pixel_type           tl_ff, tl_in;
   logic                          byp_ff, byp_in;
   pmpr_pkg::pixel_type           byp_data_ff, byp_data_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   pmpr_pkg::pixel_type           residual_ff, residual_in;
   logic                          frame_end_ff, frame_end_in;

   logic                          accept;
   logic                          row_last;
   logic                          frame_last;
   pmpr_pkg::pixel_type           ram_rdata;
   pmpr_pkg::pixel_type           top_pixel;
   pmpr_pkg::nbr_type             nbr;
   pmpr_pkg::pixel_type           residual;

   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      width_eff = width_ff;
      if (width_ff == '0) begin
         width_eff = pmpr_pkg::WIDTH_W'(1);
      end else if (width_ff > pmpr_pkg::WIDTH_LIMIT) begin
         width_eff = pmpr_pkg::WIDTH_LIMIT;
      end
      height_eff = (height_ff == '0) ? pmpr_pkg::HEIGHT_W'(1) : height_ff;
   end

   assign row_last   = ({1'b0, col_ff} + pmpr_pkg::WIDTH_W'(1)) >= width_eff;
   assign frame_last = row_last &&
                       (({1'b0, row_ff} + 17'd1) >= {1'b0, height_eff});

   assign top_pixel = byp_ff ? byp_data_ff : ram_rdata;

   always_comb begin
      nbr.first_row = (row_ff == '0);
      nbr.first_col = (col_ff == '0);
      nbr.left      = left_ff;
      nbr.top       = top_pixel;
      nbr.top_left  = tl_ff;
   end

   pmpr_predict u_predict (
      .nbr      (nbr),
      .pixel    (req_chan.pixel),
      .residual (residual)
   );

   always_comb begin
      col_in  = col_ff;
      row_in  = row_ff;
      left_in = left_ff;
      tl_in   = tl_ff;
      if (accept) begin
         if (row_last) begin
            col_in  = '0;
            row_in  = frame_last ? '0 : row_ff + pmpr_pkg::HEIGHT_W'(1);
            left_in = '0;
            tl_in   = '0;
         end else begin
            col_in  = col_ff + pmpr_pkg::COL_W'(1);
            left_in = req_chan.pixel;
            tl_in   = top_pixel;
         end
      end
      // forward a write that the next read of the same column would miss
      byp_in      = accept && (col_in == col_ff);
      byp_data_in = req_chan.pixel;

      rsp_valid_in = accept ? 1'b1 : (rsp_valid_ff && !rsp_chan.ready);
      residual_in  = accept ? residual   : residual_ff;
      frame_end_in = accept ? frame_last : frame_end_ff;
   end

   pmpr_ram #(
      .WIDTH (pmpr_pkg::PIX_W),
      .DEPTH (pmpr_pkg::MAX_WIDTH)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (accept),
      .wr_addr (col_ff),
      .wr_data (req_chan.pixel),
      .rd_addr (col_in),
      .rd_data (ram_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff     <= pmpr_pkg::WIDTH_RESET;
         height_ff    <= pmpr_pkg::HEIGHT_RESET;
         col_ff       <= '0;
         row_ff       <= '0;
         left_ff      <= '0;
         tl_ff        <= '0;
         byp_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            unique case (pmpr_pkg::csr_index_type'(csr_index))
               pmpr_pkg::CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata[pmpr_pkg::WIDTH_W-1:0];
               pmpr_pkg::CSR_IMAGE_HEIGHT: height_ff <= csr_wdata[pmpr_pkg::HEIGHT_W-1:0];
               default: ;
            endcase
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         left_ff      <= left_in;
         tl_ff        <= tl_in;
         byp_ff       <= byp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      byp_data_ff  <= byp_data_in;
      residual_ff  <= residual_in;
      frame_end_ff <= frame_end_in;
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.residual  = residual_ff;
   assign rsp_chan.frame_end = frame_end_ff;

   a_frame_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && frame_last |=> (col_ff == '0) && (row_ff == '0) && (left_ff == '0))
      else $error("position not at origin after frame end");

   a_row_wrap: assert property (@(posedge clock) disable iff (reset)
      accept && row_last |=> (col_ff == '0) && (tl_ff == '0))
      else $error("column not cleared after row end");

   a_result_loaded: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && (frame_end_ff == $past(frame_last)))
      else $error("result register missed a transfer");

   a_bypass_origin: assert property (@(posedge clock) disable iff (reset)
      byp_ff |-> $past(accept) && (col_ff == $past(col_ff)))
      else $error("forwarding without a same-column write");

   a_stall_reason: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

endmodule
